@@ hdl/nrmc_pkg.sv @@
package nrmc_pkg;

  localparam int MIN_FRAC_DIGITS = 4;
  localparam int FIELDS_REQUIRED = 12;

  localparam int FRAC_DIGITS = (MIN_FRAC_DIGITS > 3) ? MIN_FRAC_DIGITS : 3;
  localparam int FRAC_W      = $clog2(10 ** FRAC_DIGITS);
  localparam int MFIX_W      = $clog2(100 * (10 ** MIN_FRAC_DIGITS));
  localparam int MFIX_SCALE  = 10 ** (7 - MIN_FRAC_DIGITS);

  localparam logic [4:0]  FIELDS_REQ   = 5'(FIELDS_REQUIRED);
  localparam logic [2:0]  FRAC_LIM_ANG = 3'(MIN_FRAC_DIGITS);
  localparam logic [2:0]  FRAC_LIM_TIM = 3'd3;
  localparam logic [19:0] INT_MAX      = 20'd999999;
  localparam logic [13:0] DEG_MAX      = 14'd9999;
  localparam logic [29:0] LAT_MAX      = 30'd900000000;
  localparam logic [30:0] LON_MAX      = 31'd1800000000;
  localparam logic [28:0] RECIP15      = 29'h11111112;
  localparam logic [2:0]  HDR_LEN      = 3'd6;
  localparam logic [3:0]  FIELD_MAX    = 4'd15;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_DOLLAR = 2'd1,
    ST_NOT_RMC   = 2'd2,
    ST_MISSING   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CL_NONE = 2'd0,
    CL_TIME = 2'd1,
    CL_LAT  = 2'd2,
    CL_LON  = 2'd3
  } close_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_FIELDS = 4'b0100,
    PH_SKIP   = 4'b1000
  } phase_t;

  typedef struct packed {
    close_t            kind;
    logic              eos;
    status_t           status;
    logic [19:0]       acc;
    logic [13:0]       deg;
    logic [6:0]        minu;
    logic [FRAC_W-1:0] frac;
    logic [2:0]        cnt;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [19:0] time_hhmmss;
    logic [9:0]  time_millis;
    logic [29:0] latitude_e7;
    logic [30:0] longitude_e7;
  } result_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = 8'h24;
      3'd1: c = 8'h47;
      3'd2: c = 8'h50;
      3'd3: c = 8'h52;
      3'd4: c = 8'h4D;
      3'd5: c = 8'h43;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [19:0] pow10(input logic [2:0] n);
    logic [19:0] p;
    case (n)
      3'd0: p = 20'd1;
      3'd1: p = 20'd10;
      3'd2: p = 20'd100;
      3'd3: p = 20'd1000;
      3'd4: p = 20'd10000;
      3'd5: p = 20'd100000;
      3'd6: p = 20'd1000000;
      default: p = 20'd1;
    endcase
    return p;
  endfunction

  function automatic close_t field_kind(input logic [3:0] f);
    close_t k;
    case (f)
      4'd1: k = CL_TIME;
      4'd3: k = CL_LAT;
      4'd5: k = CL_LON;
      default: k = CL_NONE;
    endcase
    return k;
  endfunction

endpackage

@@ hdl/nmea_rmc_position_parser_unit.sv @@
// throughput: one byte per cycle while in_full is low; a sentence result stalls the back end
// pipeline (three stages) while the result buffer is full, else it takes one command per cycle
// a four-entry command queue and a two-entry result buffer part the front, back and output
// reset (rst_n low, synchronous) clears the parser, all stored time and position, and both queues
module nmea_rmc_position_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_end_of_sentence,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [1:0]  out_status,
  output logic [19:0] out_time_hhmmss,
  output logic [9:0]  out_time_millis,
  output logic [29:0] out_latitude_e7,
  output logic [30:0] out_longitude_e7
);
  import nrmc_pkg::*;

  logic    in_fire;
  logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t    cmd_in, cmd_head;
  result_t res;

  assign in_full = cmd_full;
  assign in_fire = in_push && !cmd_full;

  nrmc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (in_fire),
    .rx_byte  (in_rx_byte),
    .eos      (in_end_of_sentence),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  nrmc_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_head),
    .empty   (cmd_empty)
  );

  nrmc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_pop   (out_pop),
    .res_empty (out_empty),
    .res       (res)
  );

  assign out_status       = res.status;
  assign out_time_hhmmss  = res.time_hhmmss;
  assign out_time_millis  = res.time_millis;
  assign out_latitude_e7  = res.latitude_e7;
  assign out_longitude_e7 = res.longitude_e7;

`ifndef SYNTHESIS
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_latitude_e7 <= LAT_MAX) && (out_longitude_e7 <= LON_MAX))
    else $error("angle beyond limit");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_time_hhmmss <= INT_MAX) && (out_time_millis <= 10'd999))
    else $error("time beyond range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result after reset");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmd_full)
    else $error("command lost on full queue");
`endif

endmodule

@@ hdl/nrmc_front.sv @@
module nrmc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [7:0]    rx_byte,
  input  logic          eos,
  output logic          cmd_push,
  output nrmc_pkg::cmd_t cmd
);
  import nrmc_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [3:0]        field_r, field_nxt;
  logic [2:0]        hp_r, hp_nxt;
  status_t           err_r, err_nxt;
  logic [19:0]       acc_r, acc_nxt;
  logic [13:0]       deg_r, deg_nxt;
  logic [3:0]        tens_r, tens_nxt;
  logic [3:0]        ones_r, ones_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic              pt_r, pt_nxt;

  logic        is_digit;
  logic [3:0]  dig;
  logic [23:0] int_sum;
  logic [17:0] deg_sum;
  logic [23:0] frac_sum;
  logic [2:0]  lim;
  logic        comma_close;

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign dig      = rx_byte[3:0];
  assign int_sum  = {4'b0, acc_r} * 24'd10 + {20'b0, dig};
  assign deg_sum  = {4'b0, deg_r} * 18'd10 + {14'b0, tens_r};
  assign frac_sum = 24'(frac_r) * 24'd10 + {20'b0, dig};
  assign lim      = (field_r == 4'd1) ? FRAC_LIM_TIM : FRAC_LIM_ANG;

  always_comb begin
    phase_nxt   = phase_r;
    field_nxt   = field_r;
    hp_nxt      = hp_r;
    err_nxt     = err_r;
    acc_nxt     = acc_r;
    deg_nxt     = deg_r;
    tens_nxt    = tens_r;
    ones_nxt    = ones_r;
    frac_nxt    = frac_r;
    cnt_nxt     = cnt_r;
    pt_nxt      = pt_r;
    comma_close = 1'b0;
    cmd         = '0;
    cmd_push    = 1'b0;

    case (phase_r)
      PH_IDLE: begin
        if (rx_byte == CH_DOLLAR) begin
          hp_nxt    = 3'd1;
          phase_nxt = PH_HEADER;
        end else begin
          err_nxt   = ST_NO_DOLLAR;
          phase_nxt = PH_SKIP;
        end
      end
      PH_HEADER: begin
        if (rx_byte == CH_COMMA) begin
          if (hp_r == HDR_LEN) begin
            phase_nxt = PH_FIELDS;
            field_nxt = 4'd1;
            acc_nxt   = '0;
            deg_nxt   = '0;
            tens_nxt  = '0;
            ones_nxt  = '0;
            frac_nxt  = '0;
            cnt_nxt   = '0;
            pt_nxt    = 1'b0;
          end else begin
            err_nxt   = ST_NOT_RMC;
            phase_nxt = PH_SKIP;
          end
        end else if (hp_r < HDR_LEN && rx_byte == hdr_char(hp_r)) begin
          hp_nxt = hp_r + 3'd1;
        end else begin
          err_nxt   = ST_NOT_RMC;
          phase_nxt = PH_SKIP;
        end
      end
      PH_FIELDS: begin
        if (rx_byte == CH_COMMA) begin
          comma_close = 1'b1;
          if (field_r < FIELD_MAX) field_nxt = field_r + 4'd1;
          acc_nxt  = '0;
          deg_nxt  = '0;
          tens_nxt = '0;
          ones_nxt = '0;
          frac_nxt = '0;
          cnt_nxt  = '0;
          pt_nxt   = 1'b0;
        end else if (rx_byte == CH_POINT) begin
          pt_nxt = 1'b1;
        end else if (is_digit) begin
          if (!pt_r) begin
            if (int_sum > 24'(INT_MAX)) begin
              acc_nxt  = INT_MAX;
              deg_nxt  = DEG_MAX;
              tens_nxt = 4'd9;
              ones_nxt = 4'd9;
            end else begin
              acc_nxt  = int_sum[19:0];
              deg_nxt  = deg_sum[13:0];
              tens_nxt = ones_r;
              ones_nxt = dig;
            end
          end else if (cnt_r < lim) begin
            frac_nxt = frac_sum[FRAC_W-1:0];
            cnt_nxt  = cnt_r + 3'd1;
          end
        end
      end
      PH_SKIP: begin
        phase_nxt = PH_SKIP;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // field close on its comma, or at the end mark
    if (comma_close && field_kind(field_r) != CL_NONE) begin
      cmd.kind = field_kind(field_r);
      cmd.acc  = acc_r;
      cmd.deg  = deg_r;
      cmd.minu = 7'({3'b0, tens_r} * 7'd10 + {3'b0, ones_r});
      cmd.frac = frac_r;
      cmd.cnt  = cnt_r;
    end else if (eos && phase_nxt == PH_FIELDS) begin
      cmd.kind = field_kind(field_nxt);
      cmd.acc  = acc_nxt;
      cmd.deg  = deg_nxt;
      cmd.minu = 7'({3'b0, tens_nxt} * 7'd10 + {3'b0, ones_nxt});
      cmd.frac = frac_nxt;
      cmd.cnt  = cnt_nxt;
    end
    cmd.eos = eos;
    if (phase_nxt == PH_HEADER) begin
      cmd.status = (hp_nxt == HDR_LEN) ? ST_MISSING : ST_NOT_RMC;
    end else if (phase_nxt == PH_FIELDS) begin
      cmd.status = (({1'b0, field_nxt} + 5'd1) < FIELDS_REQ) ? ST_MISSING : err_nxt;
    end else begin
      cmd.status = err_nxt;
    end
    cmd_push = fire && (cmd.kind != CL_NONE || eos);

    if (eos) begin
      phase_nxt = PH_IDLE;
      field_nxt = '0;
      hp_nxt    = '0;
      err_nxt   = ST_OK;
      acc_nxt   = '0;
      deg_nxt   = '0;
      tens_nxt  = '0;
      ones_nxt  = '0;
      frac_nxt  = '0;
      cnt_nxt   = '0;
      pt_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      field_r <= '0;
      hp_r    <= '0;
      err_r   <= ST_OK;
      acc_r   <= '0;
      deg_r   <= '0;
      tens_r  <= '0;
      ones_r  <= '0;
      frac_r  <= '0;
      cnt_r   <= '0;
      pt_r    <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      field_r <= field_nxt;
      hp_r    <= hp_nxt;
      err_r   <= err_nxt;
      acc_r   <= acc_nxt;
      deg_r   <= deg_nxt;
      tens_r  <= tens_nxt;
      ones_r  <= ones_nxt;
      frac_r  <= frac_nxt;
      cnt_r   <= cnt_nxt;
      pt_r    <= pt_nxt;
    end
  end

endmodule

@@ hdl/nrmc_cmdq.sv @@
module nrmc_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nrmc_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           pop,
  output nrmc_pkg::cmd_t rd_data,
  output logic           empty
);
  import nrmc_pkg::*;

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wp_r, wp_nxt;
  logic [CMDQ_AW-1:0] rp_r, rp_nxt;
  logic [CMDQ_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (CMDQ_AW + 1)'(do_push) - (CMDQ_AW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ hdl/nrmc_back.sv @@
module nrmc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  nrmc_pkg::cmd_t    cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  input  logic              res_pop,
  output logic              res_empty,
  output nrmc_pkg::result_t res
);
  import nrmc_pkg::*;

  logic adv;

  // stage 1: minutes fixed point, whole degrees scaled
  logic              p1_v_r;
  close_t            p1_kind_r;
  logic              p1_eos_r;
  status_t           p1_st_r;
  logic [19:0]       p1_acc_r;
  logic [9:0]        p1_ms_r;
  logic [MFIX_W-1:0] p1_mfix_r;
  logic [36:0]       p1_deg7_r;

  // stage 2: minutes times decimal scale
  logic              p2_v_r;
  close_t            p2_kind_r;
  logic              p2_eos_r;
  status_t           p2_st_r;
  logic [19:0]       p2_acc_r;
  logic [9:0]        p2_ms_r;
  logic [29:0]       p2_x_r;
  logic [36:0]       p2_deg7_r;

  // stage 3: divide by sixty
  logic              p3_v_r;
  close_t            p3_kind_r;
  logic              p3_eos_r;
  status_t           p3_st_r;
  logic [19:0]       p3_acc_r;
  logic [9:0]        p3_ms_r;
  logic [24:0]       p3_q_r;
  logic [36:0]       p3_deg7_r;

  logic [19:0] st_time_r, st_time_nxt;
  logic [9:0]  st_ms_r, st_ms_nxt;
  logic [29:0] st_lat_r, st_lat_nxt;
  logic [30:0] st_lon_r, st_lon_nxt;

  result_t     rb_r [2];
  logic        rb_wp_r, rb_rp_r;
  logic [1:0]  rb_cnt_r;
  logic        rb_push, rb_pop;

  logic [39:0] ms_prod;
  logic [39:0] mfix_sum;
  logic [36:0] deg7_c;
  logic [56:0] q_prod;
  logic [36:0] angle;
  result_t     res_new;

  assign adv     = !(p3_v_r && p3_eos_r && rb_cnt_r == 2'd2);
  assign cmd_pop = adv && !cmd_empty;

  assign ms_prod  = {20'b0, 20'(cmd.frac)} * {20'b0, pow10(FRAC_LIM_TIM - cmd.cnt)};
  assign mfix_sum = {33'b0, cmd.minu} * 40'(10 ** MIN_FRAC_DIGITS)
                  + {20'b0, 20'(cmd.frac)} * {20'b0, pow10(FRAC_LIM_ANG - cmd.cnt)};
  assign deg7_c   = {23'b0, cmd.deg} * 37'd10000000;
  assign q_prod   = {29'b0, p2_x_r[29:2]} * {28'b0, RECIP15};
  assign angle    = p3_deg7_r + {12'b0, p3_q_r};

  always_comb begin
    st_time_nxt = st_time_r;
    st_ms_nxt   = st_ms_r;
    st_lat_nxt  = st_lat_r;
    st_lon_nxt  = st_lon_r;
    if (adv && p3_v_r) begin
      case (p3_kind_r)
        CL_TIME: begin
          st_time_nxt = p3_acc_r;
          st_ms_nxt   = p3_ms_r;
        end
        CL_LAT: st_lat_nxt = (angle > 37'(LAT_MAX)) ? LAT_MAX : angle[29:0];
        CL_LON: st_lon_nxt = (angle > 37'(LON_MAX)) ? LON_MAX : angle[30:0];
        default: ;
      endcase
    end
    res_new.status       = p3_st_r;
    res_new.time_hhmmss  = st_time_nxt;
    res_new.time_millis  = st_ms_nxt;
    res_new.latitude_e7  = st_lat_nxt;
    res_new.longitude_e7 = st_lon_nxt;
  end

  assign rb_push   = adv && p3_v_r && p3_eos_r;
  assign res_empty = (rb_cnt_r == 2'd0);
  assign rb_pop    = res_pop && !res_empty;
  assign res       = rb_r[rb_rp_r];

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_kind_r <= cmd.kind;
      p1_eos_r  <= cmd.eos;
      p1_st_r   <= cmd.status;
      p1_acc_r  <= cmd.acc;
      p1_ms_r   <= ms_prod[9:0];
      p1_mfix_r <= mfix_sum[MFIX_W-1:0];
      p1_deg7_r <= deg7_c;

      p2_kind_r <= p1_kind_r;
      p2_eos_r  <= p1_eos_r;
      p2_st_r   <= p1_st_r;
      p2_acc_r  <= p1_acc_r;
      p2_ms_r   <= p1_ms_r;
      p2_x_r    <= 30'(40'(p1_mfix_r) * 40'(MFIX_SCALE));
      p2_deg7_r <= p1_deg7_r;

      p3_kind_r <= p2_kind_r;
      p3_eos_r  <= p2_eos_r;
      p3_st_r   <= p2_st_r;
      p3_acc_r  <= p2_acc_r;
      p3_ms_r   <= p2_ms_r;
      p3_q_r    <= q_prod[56:32];
      p3_deg7_r <= p2_deg7_r;
    end
    if (rb_push) rb_r[rb_wp_r] <= res_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r    <= 1'b0;
      p2_v_r    <= 1'b0;
      p3_v_r    <= 1'b0;
      st_time_r <= '0;
      st_ms_r   <= '0;
      st_lat_r  <= '0;
      st_lon_r  <= '0;
      rb_wp_r   <= 1'b0;
      rb_rp_r   <= 1'b0;
      rb_cnt_r  <= '0;
    end else begin
      if (adv) begin
        p1_v_r <= !cmd_empty;
        p2_v_r <= p1_v_r;
        p3_v_r <= p2_v_r;
      end
      st_time_r <= st_time_nxt;
      st_ms_r   <= st_ms_nxt;
      st_lat_r  <= st_lat_nxt;
      st_lon_r  <= st_lon_nxt;
      if (rb_push) rb_wp_r <= !rb_wp_r;
      if (rb_pop) rb_rp_r <= !rb_rp_r;
      rb_cnt_r <= rb_cnt_r + 2'(rb_push) - 2'(rb_pop);
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  import nrmc_pkg::*;

  typedef enum logic [1:0] {
    P_IDLE   = 2'd0,
    P_HEADER = 2'd1,
    P_FIELDS = 2'd2,
    P_SKIP   = 2'd3
  } prs_phase_t;

  typedef struct {
    logic [7:0] b;
    logic       eos;
    bit         drain;
  } char_item_t;

  localparam logic [7:0] C_DOLLAR = 8'h24;
  localparam logic [7:0] C_COMMA  = 8'h2C;
  localparam logic [7:0] C_POINT  = 8'h2E;
  localparam logic [7:0] C_ZERO   = 8'h30;
  localparam logic [7:0] C_NINE   = 8'h39;
  localparam int         HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        in_end_of_sentence = 1'b0;
  logic        out_pop = 1'b0;
  logic        out_empty;
  logic [1:0]  out_status;
  logic [19:0] out_time_hhmmss;
  logic [9:0]  out_time_millis;
  logic [29:0] out_latitude_e7;
  logic [30:0] out_longitude_e7;

  nmea_rmc_position_parser_unit u_top (.*);

  always #4 clk = ~clk;

  // parser mirror
  prs_phase_t  m_phase = P_IDLE;
  int unsigned m_field = 0, m_hpos = 0, m_err = 0;
  int unsigned m_int = 0, m_frac = 0, m_fcnt = 0, m_point = 0;
  int unsigned m_time = 0, m_ms = 0, m_lat = 0, m_lon = 0;
  string       hdr_s = "$GPRMC";

  char_item_t  pending_chars[$];
  result_t     expected_reports[$];
  logic [7:0]  sent[$];
  int          errors = 0;
  int          n_chars = 0, n_reports = 0;
  int          n_status[4] = '{0, 0, 0, 0};
  int          tx_gap = 0, rx_gap = 0, rx_hold = 0;
  bit          burst = 0, hold_done = 0, drain_done = 0;

  function automatic longint unsigned pw10(int unsigned n);
    longint unsigned p = 1;
    for (int i = 0; i < n; i++) p *= 10;
    return p;
  endfunction

  function int unsigned angle_e7(longint unsigned lim);
    longint unsigned dg, mn, mfix, v;
    int unsigned cnt;
    dg = m_int / 100;
    mn = m_int % 100;
    cnt = (m_fcnt > MIN_FRAC_DIGITS) ? MIN_FRAC_DIGITS : m_fcnt;
    mfix = mn * pw10(MIN_FRAC_DIGITS) + longint'(m_frac) * pw10(MIN_FRAC_DIGITS - cnt);
    v = dg * 64'd10000000 + (mfix * 64'd10000000) / (64'd60 * pw10(MIN_FRAC_DIGITS));
    if (v > lim) v = lim;
    return int'(v);
  endfunction

  function void clear_acc();
    m_int = 0; m_frac = 0; m_fcnt = 0; m_point = 0;
  endfunction

  function void close_field();
    int unsigned cnt;
    cnt = (m_fcnt > 3) ? 3 : m_fcnt;
    if (m_field == 1) begin
      m_time = m_int;
      m_ms = m_frac * int'(pw10(3 - cnt));
    end else if (m_field == 3) begin
      m_lat = angle_e7(64'd900000000);
    end else if (m_field == 5) begin
      m_lon = angle_e7(64'd1800000000);
    end
  endfunction

  function void parse_char(logic [7:0] b, logic eos);
    result_t r;
    int unsigned lim;
    case (m_phase)
      P_IDLE: begin
        if (b == C_DOLLAR) begin
          m_hpos = 1; m_phase = P_HEADER;
        end else begin
          m_err = ST_NO_DOLLAR; m_phase = P_SKIP;
        end
      end
      P_HEADER: begin
        if (b == C_COMMA) begin
          if (m_hpos == 6) begin
            m_phase = P_FIELDS; m_field = 1; clear_acc();
          end else begin
            m_err = ST_NOT_RMC; m_phase = P_SKIP;
          end
        end else if (m_hpos < 6 && b == hdr_s[m_hpos]) begin
          m_hpos++;
        end else begin
          m_err = ST_NOT_RMC; m_phase = P_SKIP;
        end
      end
      P_FIELDS: begin
        if (b == C_COMMA) begin
          close_field();
          if (m_field < 15) m_field++;
          clear_acc();
        end else if (b == C_POINT) begin
          m_point = 1;
        end else if (b >= C_ZERO && b <= C_NINE) begin
          if (!m_point) begin
            m_int = m_int * 10 + (b - C_ZERO);
            if (m_int > 999999) m_int = 999999;
          end else begin
            lim = (m_field == 1) ? 3 : MIN_FRAC_DIGITS;
            if (m_fcnt < lim) begin
              m_frac = m_frac * 10 + (b - C_ZERO);
              m_fcnt++;
            end
          end
        end
      end
      default: ;
    endcase
    if (eos) begin
      if (m_phase == P_HEADER) m_err = (m_hpos == 6) ? ST_MISSING : ST_NOT_RMC;
      else if (m_phase == P_FIELDS) begin
        close_field();
        if (m_field + 1 < FIELDS_REQUIRED) m_err = ST_MISSING;
      end
      r.status = status_t'(m_err[1:0]);
      r.time_hhmmss = m_time[19:0];
      r.time_millis = m_ms[9:0];
      r.latitude_e7 = m_lat[29:0];
      r.longitude_e7 = m_lon[30:0];
      expected_reports.push_back(r);
      m_phase = P_IDLE; m_field = 0; m_hpos = 0; m_err = 0;
      clear_acc();
    end
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch on %s at report %0d: got %0d, expected %0d", what, n_reports, got, want);
    errors++;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst_n) begin
      logic push_n;
      push_n = 1'b0;
      if (in_push && !in_full) begin
        parse_char(in_rx_byte, in_end_of_sentence);
        void'(pending_chars.pop_front());
        n_chars++;
        if (n_chars % 250 == 0) burst = ~burst;
        tx_gap = (burst || rx_hold > 0) ? 0 : $urandom_range(0, 17);
      end
      if (tx_gap > 0 && rx_hold == 0) begin
        tx_gap--;
      end else if (pending_chars.size() > 0 &&
                   (!pending_chars[0].drain || expected_reports.size() == 0)) begin
        push_n = 1'b1;
        in_rx_byte <= pending_chars[0].b;
        in_end_of_sentence <= pending_chars[0].eos;
      end
      in_push <= push_n;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst_n) begin
      logic pop_n;
      if (out_pop && !out_empty) begin
        result_t w;
        if (expected_reports.size() == 0) begin
          report("unexpected report", out_status, 0);
        end else begin
          w = expected_reports.pop_front();
          if (out_status !== w.status) report("status", out_status, w.status);
          if (out_time_hhmmss !== w.time_hhmmss)
            report("time_hhmmss", out_time_hhmmss, w.time_hhmmss);
          if (out_time_millis !== w.time_millis)
            report("time_millis", out_time_millis, w.time_millis);
          if (out_latitude_e7 !== w.latitude_e7)
            report("latitude_e7", out_latitude_e7, w.latitude_e7);
          if (out_longitude_e7 !== w.longitude_e7)
            report("longitude_e7", out_longitude_e7, w.longitude_e7);
          n_status[w.status]++;
        end
        n_reports++;
        rx_gap = burst ? 0 : $urandom_range(0, 17);
        if (n_reports == 20 && !hold_done) begin
          rx_hold = HOLD_CYCLES;
          hold_done = 1;
        end
      end
      pop_n = 1'b0;
      if (rx_hold > 0) rx_hold--;
      else if (rx_gap > 0) rx_gap--;
      else pop_n = 1'b1;
      out_pop <= pop_n;
    end
  end

  task automatic flush_sentence(bit drain_first);
    char_item_t it;
    foreach (sent[i]) begin
      it.b = sent[i];
      it.eos = (i == sent.size() - 1);
      it.drain = drain_first && (i == 0);
      pending_chars.push_back(it);
    end
    sent.delete();
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) sent.push_back(s[i]);
  endtask

  task automatic add_digits(int n);
    repeat (n) sent.push_back(8'(C_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic say(string s);
    add_text(s);
    flush_sentence(0);
  endtask

  task automatic random_sentence(bit drain_first);
    int nf, k;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) sent.push_back(8'($urandom_range(0, 255)));
      flush_sentence(drain_first);
      return;
    end
    add_text("$GPRMC");
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(0, 6);
      if (k == 6) sent.push_back(8'($urandom_range(0, 255)));
      else sent[k] = 8'($urandom_range(0, 255));
    end
    k = $urandom_range(0, 3);
    nf = (k == 0) ? $urandom_range(0, 15) : $urandom_range(10, 13);
    for (int f = 1; f <= nf; f++) begin
      sent.push_back(C_COMMA);
      if (f == 1 || f == 3 || f == 5) begin
        if ($urandom_range(0, 11) == 0) continue;
        k = $urandom_range(0, 7);
        add_digits(k == 0 ? $urandom_range(0, 9) : (f == 1 ? 6 : (f == 3 ? 4 : 5)));
        if ($urandom_range(0, 5) != 0) begin
          sent.push_back(C_POINT);
          add_digits($urandom_range(0, 6));
          if ($urandom_range(0, 15) == 0) begin
            sent.push_back(C_POINT);
            add_digits($urandom_range(0, 3));
          end
        end
      end else begin
        repeat ($urandom_range(0, 3)) sent.push_back(8'($urandom_range(32, 126)));
      end
      if ($urandom_range(0, 19) == 0) sent.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1)) begin
      add_text("*");
      sent.push_back(8'($urandom_range(0, 255)));
      sent.push_back(8'($urandom_range(0, 255)));
      sent.push_back(8'h0D);
      sent.push_back(8'h0A);
    end
    flush_sentence(drain_first);
  endtask

  initial begin
    sent.push_back(8'h00); flush_sentence(0);
    sent.push_back(8'hFF); sent.push_back(8'h24); flush_sentence(0);
    say("$");
    say("$GPR");
    say("$GPRMC");
    say("$GPRMX,1,2");
    say("$GPRMCC,1");
    say("$GPRMC,123519.25,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W");
    say("$GPRMC,,,,,,,,,,,");
    say("$GPRMC,99999999.99999,A,99999.99999,S,999999.9999,W,,,,,,,,,,,");
    say("$GPRMC,000000.000,A,9000.0000,N,18000.0000,E,,,,,");
    say("$GPRMC,12.3.4,A,1-2a3.4.5,N,0\r1\n2,E,,,,,,");
    say("$GPRMC,235959.999,V,8959.9999,N,17959.9999,W,,,,,,");
    say("$GPRMC,1,A,8960.0,N,17960,W,");
    repeat (3) random_sentence(0);
    while (pending_chars.size() < 1900) begin
      if (!drain_done && pending_chars.size() > 1000) begin
        drain_done = 1;
        random_sentence(1);
      end else begin
        random_sentence(0);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    wait (pending_chars.size() == 0);
    @(posedge clk);
    wait (expected_reports.size() == 0);
    repeat (20) @(posedge clk);
    $display("sent %0d characters, checked %0d reports", n_chars, n_reports);
    $display("status mix: ok %0d, no dollar %0d, not rmc %0d, missing field %0d",
             n_status[0], n_status[1], n_status[2], n_status[3]);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
